### design/rrss_pkg.sv
// ============================================================================
// rrss_pkg: shared types and constants for the radio report send scheduler
// Holds the poll and result item layouts, the register indexes and the
// transmission outcome codes.
// ============================================================================
package rrss_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned TXTO_W     = 31;
    localparam int unsigned ACKS_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_MIN_GAP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_DOWN_TO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_TIMEOUT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_UP_ACKS   = 3'd4;

    // Reset values of the registers.
    localparam logic [TIME_W-1:0] RST_ANALOG_MIN_GAP = 32'd900;
    localparam logic [TIME_W-1:0] RST_HEARTBEAT      = 32'd50000;
    localparam logic [TIME_W-1:0] RST_LINK_DOWN_TO   = 32'd1000000;
    localparam logic [TXTO_W-1:0] RST_TX_TIMEOUT     = 31'd5000;
    localparam logic [ACKS_W-1:0] RST_LINK_UP_ACKS   = 8'd3;

    // Outcome of an in-flight transmission.
    localparam logic [1:0] TX_NONE    = 2'd0;
    localparam logic [1:0] TX_ACKED   = 2'd1;
    localparam logic [1:0] TX_RETRY   = 2'd2;
    localparam logic [1:0] TX_TIMEOUT = 2'd3;

    typedef struct packed {
        logic [31:0] now_us;
        logic [15:0] buttons;
        logic [7:0]  dpad;
        logic [15:0] left_x;
        logic [15:0] left_y;
        logic [15:0] right_x;
        logic [15:0] right_y;
        logic [7:0]  left_trigger;
        logic [7:0]  right_trigger;
        logic [7:0]  input_mode;
        logic        ack_seen;
        logic        retries_exhausted;
    } rrss_in_t;

    typedef struct packed {
        logic       send_frame;
        logic [1:0] tx_outcome;
        logic       flush_radio;
        logic       link_up;
        logic       link_changed;
        logic       busy_res;
    } rrss_out_t;

endpackage

### design/radio_report_send_scheduler.sv
// ============================================================================
// radio_report_send_scheduler: decides per poll whether to send a report
// Tracks the in-flight radio transmission, the link state and the last sent
// snapshot, and tells the radio driver when to send or flush.
// ============================================================================
// Usage:
// A poll item (time, controller snapshot, radio status bits) enters on the
// in_valid/in_ready channel. One result item per poll leaves on the
// out_valid/out_ready channel, in poll order.
// The poll is held in an input register; the decision logic runs between
// that register and the result register, from which the result is presented.
// One poll is taken every cycle while the receiver takes results.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more poll; after that in_ready follows out_ready.
// Registers are written on the cfg_valid/cfg_ready channel (always ready) by
// index and should only be written while no poll is in progress.
// Reset clears the pipeline valid flags, the link and transmission state and
// the remembered snapshot, and loads the register defaults.
// ============================================================================
module radio_report_send_scheduler
    import rrss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rrss_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rrss_out_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [TIME_W-1:0] gap_reg;
    logic [TIME_W-1:0] hb_reg;
    logic [TIME_W-1:0] link_to_reg;
    logic [TXTO_W-1:0] tx_to_reg;
    logic [ACKS_W-1:0] up_acks_reg;

    // Pipeline registers.
    logic      in_valid_reg;
    rrss_in_t  in_item_reg;
    logic      out_valid_reg;
    rrss_out_t out_item_reg;
    logic      advance;

    // Scheduler state.
    logic              in_flight_reg, in_flight_next;
    logic              dirty_reg, dirty_next;
    logic              link_reg, link_next;
    logic [ACKS_W-1:0] ack_count_reg, ack_count_next;
    logic [TIME_W-1:0] last_ack_reg, last_ack_next;
    logic [TIME_W-1:0] last_send_reg;
    logic [TIME_W-1:0] send_start_reg;
    logic [15:0]       sent_buttons_reg;
    logic [7:0]        sent_dpad_reg;
    logic [15:0]       sent_axes_reg [4];
    logic [7:0]        sent_trig_reg [2];

    rrss_out_t         out_item_next;
    logic              send;
    logic [1:0]        outcome;
    logic              digital_changed, analog_changed;
    logic              link_drop, link_mid;
    logic [ACKS_W-1:0] ack_mid, ack_inc;
    logic [TIME_W-1:0] since_ack, since_start, since_send;
    logic              tx_expired;
    logic              flight_mid, dirty_mid;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg     <= RST_ANALOG_MIN_GAP;
            hb_reg      <= RST_HEARTBEAT;
            link_to_reg <= RST_LINK_DOWN_TO;
            tx_to_reg   <= RST_TX_TIMEOUT;
            up_acks_reg <= RST_LINK_UP_ACKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ANALOG_MIN_GAP: gap_reg     <= cfg_data;
                CFG_HEARTBEAT:      hb_reg      <= cfg_data;
                CFG_LINK_DOWN_TO:   link_to_reg <= cfg_data;
                CFG_TX_TIMEOUT:     tx_to_reg   <= cfg_data[TXTO_W-1:0];
                CFG_LINK_UP_ACKS:   up_acks_reg <= cfg_data[ACKS_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        digital_changed = (in_item_reg.buttons != sent_buttons_reg) ||
                          (in_item_reg.dpad != sent_dpad_reg);
        analog_changed  = (in_item_reg.left_x != sent_axes_reg[0]) ||
                          (in_item_reg.left_y != sent_axes_reg[1]) ||
                          (in_item_reg.right_x != sent_axes_reg[2]) ||
                          (in_item_reg.right_y != sent_axes_reg[3]) ||
                          (in_item_reg.left_trigger != sent_trig_reg[0]) ||
                          (in_item_reg.right_trigger != sent_trig_reg[1]);

        // Ack silence takes the link down before the transmission is looked at.
        since_ack = in_item_reg.now_us - last_ack_reg;
        link_drop = link_reg && (since_ack >= link_to_reg);
        link_mid  = link_reg && !link_drop;
        ack_mid   = link_drop ? '0 : ack_count_reg;

        // A negative elapsed time never counts as a timeout.
        since_start = in_item_reg.now_us - send_start_reg;
        tx_expired  = !since_start[TIME_W-1] &&
                      (since_start[TIME_W-2:0] >= tx_to_reg);

        outcome = TX_NONE;
        if (in_flight_reg)
        begin
            if (tx_expired)
                outcome = TX_TIMEOUT;
            else if (in_item_reg.ack_seen)
                outcome = TX_ACKED;
            else if (in_item_reg.retries_exhausted)
                outcome = TX_RETRY;
        end

        ack_inc        = (ack_mid == '1) ? ack_mid : ack_mid + 8'd1;
        link_next      = link_mid;
        ack_count_next = ack_mid;
        last_ack_next  = last_ack_reg;
        if (outcome == TX_ACKED)
        begin
            last_ack_next = in_item_reg.now_us;
            if (!link_mid)
            begin
                ack_count_next = ack_inc;
                link_next      = (ack_inc >= up_acks_reg);
            end
        end

        flight_mid = in_flight_reg && (outcome == TX_NONE);
        dirty_mid  = dirty_reg || (flight_mid && (digital_changed || analog_changed));

        since_send = in_item_reg.now_us - last_send_reg;
        send = !flight_mid &&
               (dirty_mid || digital_changed ||
                (analog_changed && (since_send >= gap_reg)) ||
                (since_send >= hb_reg));

        in_flight_next = flight_mid || send;
        dirty_next     = dirty_mid && !send;

        out_item_next.send_frame   = send;
        out_item_next.tx_outcome   = outcome;
        out_item_next.flush_radio  = (outcome == TX_TIMEOUT) || (outcome == TX_RETRY);
        out_item_next.link_up      = link_next;
        out_item_next.link_changed = link_next != link_reg;
        out_item_next.busy_res     = in_flight_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_data;
        if (advance)
            out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg    <= 1'b0;
            dirty_reg        <= 1'b0;
            link_reg         <= 1'b0;
            ack_count_reg    <= '0;
            last_ack_reg     <= '0;
            last_send_reg    <= '0;
            send_start_reg   <= '0;
            sent_buttons_reg <= '0;
            sent_dpad_reg    <= '0;
            sent_axes_reg    <= '{default: '0};
            sent_trig_reg    <= '{default: '0};
        end
        else if (advance)
        begin
            in_flight_reg <= in_flight_next;
            dirty_reg     <= dirty_next;
            link_reg      <= link_next;
            ack_count_reg <= ack_count_next;
            last_ack_reg  <= last_ack_next;
            if (send)
            begin
                last_send_reg    <= in_item_reg.now_us;
                send_start_reg   <= in_item_reg.now_us;
                sent_buttons_reg <= in_item_reg.buttons;
                sent_dpad_reg    <= in_item_reg.dpad;
                sent_axes_reg[0] <= in_item_reg.left_x;
                sent_axes_reg[1] <= in_item_reg.left_y;
                sent_axes_reg[2] <= in_item_reg.right_x;
                sent_axes_reg[3] <= in_item_reg.right_y;
                sent_trig_reg[0] <= in_item_reg.left_trigger;
                sent_trig_reg[1] <= in_item_reg.right_trigger;
            end
        end
    end

    // A pending change is only ever held while a transmission is in flight.
    a_dirty_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        dirty_reg |-> in_flight_reg)
        else $error("dirty set with no transmission in flight");

    // An outcome can only be reported for a transmission that was in flight.
    a_outcome_needs_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (outcome != TX_NONE)) |-> in_flight_reg)
        else $error("outcome reported with nothing in flight");

    // A send leaves the radio busy.
    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && send) |=> (in_flight_reg && out_item_reg.busy_res))
        else $error("send did not leave a transmission in flight");

    // The link state in a result is the state the scheduler kept.
    a_link_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_item_reg.link_up == link_reg))
        else $error("reported link state differs from the kept state");

endmodule

### verif/tb.sv
// ============================================================================
// tb: self-checking bench for the radio report send scheduler
// Drives polls and register writes over valid/ready channels, predicts each
// result item with a scheduler model or a directed row, and compares every
// field of every result in order. A directed table comes first, then random
// polls under several register settings and idling patterns.
// ============================================================================
module tb;
    import rrss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned ROWS         = 21;
    localparam int unsigned PER_SET      = 165;
    localparam int unsigned HOLD_CYCLES  = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
    localparam rrss_out_t NO_RES = '0;

    typedef struct packed {
        rrss_in_t  poll;
        logic      typed;
        rrss_out_t want;
    } poll_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    rrss_in_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    rrss_out_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Scheduler state as the bench sees it.
    logic        p_busy;
    logic        p_dirty;
    logic        p_link;
    logic [7:0]  p_acks;
    logic [31:0] p_ack_at;
    logic [31:0] p_sent_at;
    logic [31:0] p_start_at;
    rrss_in_t    p_snap;

    logic [31:0] gap_us;
    logic [31:0] beat_us;
    logic [31:0] drop_us;
    logic [30:0] txto_us;
    logic [7:0]  acks_needed;

    rrss_out_t   pending_res[$];
    rrss_out_t   res_want;
    int unsigned fail_cnt;
    int unsigned res_cnt;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_left;
    logic        hold_req;
    logic [31:0] t_now;
    rrss_in_t    cur;
    poll_row_t   plan [ROWS];

    radio_report_send_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic rrss_in_t mk_poll(input logic [31:0] now, input logic [15:0] btn,
                                         input logic [7:0] dpad, input logic [15:0] axis,
                                         input logic [7:0] trig, input logic [7:0] mode,
                                         input logic ack, input logic rfail);
        rrss_in_t p;
        p.now_us            = now;
        p.buttons           = btn;
        p.dpad              = dpad;
        p.left_x            = axis;
        p.left_y            = axis;
        p.right_x           = axis;
        p.right_y           = axis;
        p.left_trigger      = trig;
        p.right_trigger     = trig;
        p.input_mode        = mode;
        p.ack_seen          = ack;
        p.retries_exhausted = rfail;
        return p;
    endfunction

    function automatic rrss_out_t mk_res(input logic send, input logic [1:0] outcome,
                                         input logic flush, input logic up,
                                         input logic chg, input logic busy);
        return {send, outcome, flush, up, chg, busy};
    endfunction

    // Advances the scheduler state by one poll and returns the result item.
    function automatic rrss_out_t schedule_poll(input rrss_in_t p);
        rrss_out_t   r;
        logic        dig;
        logic        ana;
        logic        was_up;
        logic [31:0] dt;
        r      = '0;
        was_up = p_link;
        dig    = (p.buttons != p_snap.buttons) || (p.dpad != p_snap.dpad);
        ana    = (p.left_x != p_snap.left_x) || (p.left_y != p_snap.left_y) ||
                 (p.right_x != p_snap.right_x) || (p.right_y != p_snap.right_y) ||
                 (p.left_trigger != p_snap.left_trigger) ||
                 (p.right_trigger != p_snap.right_trigger);
        dt = p.now_us - p_ack_at;
        if (p_link && dt >= drop_us)
        begin
            p_link = 1'b0;
            p_acks = 8'd0;
        end
        if (p_busy)
        begin
            // A negative time difference never counts as a timeout.
            dt = p.now_us - p_start_at;
            if (!dt[31] && dt >= {1'b0, txto_us})
            begin
                r.tx_outcome  = TX_TIMEOUT;
                r.flush_radio = 1'b1;
            end
            else if (p.ack_seen)
            begin
                r.tx_outcome = TX_ACKED;
            end
            else if (p.retries_exhausted)
            begin
                r.tx_outcome  = TX_RETRY;
                r.flush_radio = 1'b1;
            end
            if (r.tx_outcome == TX_NONE)
            begin
                if (dig || ana)
                    p_dirty = 1'b1;
            end
            else
            begin
                p_busy = 1'b0;
                if (r.tx_outcome == TX_ACKED)
                begin
                    p_ack_at = p.now_us;
                    if (!p_link)
                    begin
                        if (p_acks != 8'hFF)
                            p_acks = p_acks + 8'd1;
                        if (p_acks >= acks_needed)
                            p_link = 1'b1;
                    end
                end
            end
        end
        if (!p_busy)
        begin
            dt = p.now_us - p_sent_at;
            if (p_dirty || dig || (ana && dt >= gap_us) || dt >= beat_us)
            begin
                r.send_frame = 1'b1;
                p_snap       = p;
                p_sent_at    = p.now_us;
                p_start_at   = p.now_us;
                p_dirty      = 1'b0;
                p_busy       = 1'b1;
            end
        end
        r.link_up      = p_link;
        r.link_changed = (p_link != was_up);
        r.busy_res     = p_busy;
        return r;
    endfunction

    task automatic send_poll(input rrss_in_t p, input logic typed, input rrss_out_t want);
        rrss_out_t guess;
        while (hold_left == 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        guess = schedule_poll(p);
        pending_res.push_back(typed ? want : guess);
    endtask

    task automatic next_poll(output rrss_in_t p);
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 55)
            t_now = t_now + $urandom_range(1500, 0);
        else if (r < 75)
            t_now = t_now + $urandom_range(30000, 0);
        else if (r < 85)
            t_now = t_now + $urandom_range(2000000, 0);
        else if (r < 92)
            t_now = t_now + $urandom;
        else if (r < 97)
            t_now = t_now - $urandom_range(6000, 1);
        cur.now_us = t_now;
        if ($urandom_range(99, 0) < 12)
        begin
            case ($urandom_range(2, 0))
                0: cur.buttons = cur.buttons ^ (16'h1 << $urandom_range(15, 0));
                1: cur.dpad = 8'($urandom);
                default: cur.buttons = 16'($urandom);
            endcase
        end
        if ($urandom_range(99, 0) < 25)
        begin
            case ($urandom_range(5, 0))
                0: cur.left_x = 16'($urandom);
                1: cur.left_y = 16'($urandom);
                2: cur.right_x = 16'($urandom);
                3: cur.right_y = 16'($urandom);
                4: cur.left_trigger = 8'($urandom);
                default: cur.right_trigger = 8'($urandom);
            endcase
        end
        cur.input_mode        = 8'($urandom);
        cur.ack_seen          = ($urandom_range(99, 0) < 35);
        cur.retries_exhausted = ($urandom_range(99, 0) < 20);
        p = cur;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ANALOG_MIN_GAP: gap_us = data;
            CFG_HEARTBEAT:      beat_us = data;
            CFG_LINK_DOWN_TO:   drop_us = data;
            CFG_TX_TIMEOUT:     txto_us = data[TXTO_W-1:0];
            CFG_LINK_UP_ACKS:   acks_needed = data[ACKS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input int unsigned set);
        case (set)
            1:
            begin
                write_reg(CFG_ANALOG_MIN_GAP, 32'd0);
                write_reg(CFG_HEARTBEAT, 32'd0);
                write_reg(CFG_LINK_DOWN_TO, 32'd1);
                write_reg(CFG_TX_TIMEOUT, 32'd1);
                write_reg(CFG_LINK_UP_ACKS, 32'd0);
            end
            2:
            begin
                write_reg(CFG_ANALOG_MIN_GAP, 32'hFFFF_FFFF);
                write_reg(CFG_HEARTBEAT, 32'hFFFF_FFFF);
                write_reg(CFG_LINK_DOWN_TO, 32'hFFFF_FFFF);
                write_reg(CFG_TX_TIMEOUT, 32'hFFFF_FFFF);
                write_reg(CFG_LINK_UP_ACKS, 32'hFFFF_FFFF);
            end
            3:
            begin
                write_reg(CFG_ANALOG_MIN_GAP, 32'd500);
                write_reg(CFG_HEARTBEAT, 32'd3000);
                write_reg(CFG_LINK_DOWN_TO, 32'd20000);
                write_reg(CFG_TX_TIMEOUT, 32'd800);
                write_reg(CFG_LINK_UP_ACKS, 32'd1);
                write_reg(CFG_NO_REG, 32'hFFFF_FFFF);
            end
            4:
            begin
                write_reg(CFG_ANALOG_MIN_GAP, $urandom_range(4000, 0));
                write_reg(CFG_HEARTBEAT, $urandom_range(20000, 1));
                write_reg(CFG_LINK_DOWN_TO, $urandom_range(60000, 1));
                write_reg(CFG_TX_TIMEOUT, $urandom_range(6000, 1));
                write_reg(CFG_LINK_UP_ACKS, $urandom_range(6, 1));
            end
            default:
            begin
                write_reg(CFG_ANALOG_MIN_GAP, RST_ANALOG_MIN_GAP);
                write_reg(CFG_HEARTBEAT, RST_HEARTBEAT);
                write_reg(CFG_LINK_DOWN_TO, RST_LINK_DOWN_TO);
                write_reg(CFG_TX_TIMEOUT, {1'b0, RST_TX_TIMEOUT});
                write_reg(CFG_LINK_UP_ACKS, {24'd0, RST_LINK_UP_ACKS});
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off on request so the
    // pipeline fills up and the input side stalls.
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            res_cnt = res_cnt + 1;
            if (pending_res.size() == 0)
            begin
                fail_cnt = fail_cnt + 1;
                if (fail_cnt <= 10)
                    $display("result %0d arrived with no item expected", res_cnt);
            end
            else
            begin
                res_want = pending_res.pop_front();
                if (out_data.send_frame !== res_want.send_frame ||
                    out_data.tx_outcome !== res_want.tx_outcome ||
                    out_data.flush_radio !== res_want.flush_radio ||
                    out_data.link_up !== res_want.link_up ||
                    out_data.link_changed !== res_want.link_changed ||
                    out_data.busy_res !== res_want.busy_res)
                begin
                    fail_cnt = fail_cnt + 1;
                    if (fail_cnt <= 10)
                        $display({"result %0d mismatch: expected send=%0b outcome=%0d ",
                                  "flush=%0b up=%0b changed=%0b busy=%0b, got send=%0b ",
                                  "outcome=%0d flush=%0b up=%0b changed=%0b busy=%0b"},
                                 res_cnt, res_want.send_frame, res_want.tx_outcome,
                                 res_want.flush_radio, res_want.link_up,
                                 res_want.link_changed, res_want.busy_res,
                                 out_data.send_frame, out_data.tx_outcome,
                                 out_data.flush_radio, out_data.link_up,
                                 out_data.link_changed, out_data.busy_res);
                end
            end
        end
    end

    initial
    begin
        int unsigned cyc;
        cyc = 0;
        while (cyc < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cyc = cyc + 1;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rrss_in_t p;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hold_req  = 1'b0;
        fail_cnt  = 0;
        res_cnt   = 0;

        p_busy      = 1'b0;
        p_dirty     = 1'b0;
        p_link      = 1'b0;
        p_acks      = 8'd0;
        p_ack_at    = 32'd0;
        p_sent_at   = 32'd0;
        p_start_at  = 32'd0;
        p_snap      = '0;
        gap_us      = RST_ANALOG_MIN_GAP;
        beat_us     = RST_HEARTBEAT;
        drop_us     = RST_LINK_DOWN_TO;
        txto_us     = RST_TX_TIMEOUT;
        acks_needed = RST_LINK_UP_ACKS;

        send_idle_pct = 31;
        recv_idle_pct = 88;

        // Directed polls under the reset register values. Status bits with
        // nothing in flight, ack beating retry failure, timeout beating ack,
        // negative time differences, link up and down, and time wrap.
        plan[0]  = {mk_poll(32'd0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b1),
                    1'b1, mk_res(1'b0, TX_NONE, 1'b0, 1'b0, 1'b0, 1'b0)};
        plan[1]  = {mk_poll(32'd10, 16'hFFFF, 8'hFF, 16'h0000, 8'h00, 8'h5A, 1'b0, 1'b0),
                    1'b1, mk_res(1'b1, TX_NONE, 1'b0, 1'b0, 1'b0, 1'b1)};
        plan[2]  = {mk_poll(32'd20, 16'hFFFF, 8'hFF, 16'h0000, 8'h00, 8'h5A, 1'b1, 1'b1),
                    1'b1, mk_res(1'b0, TX_ACKED, 1'b0, 1'b0, 1'b0, 1'b0)};
        plan[3]  = {mk_poll(32'd30, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b0, 1'b0),
                    1'b0, NO_RES};
        plan[4]  = {mk_poll(32'd1000, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b0, 1'b0),
                    1'b0, NO_RES};
        plan[5]  = {mk_poll(32'd1100, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b0, 1'b1),
                    1'b1, mk_res(1'b0, TX_RETRY, 1'b1, 1'b0, 1'b0, 1'b0)};
        plan[6]  = {mk_poll(32'd1200, 16'h0000, 8'hFF, 16'hFFFF, 8'hFF, 8'h00, 1'b0, 1'b0),
                    1'b0, NO_RES};
        plan[7]  = {mk_poll(32'd1300, 16'h0001, 8'hFF, 16'hFFFF, 8'hFF, 8'h11, 1'b0, 1'b0),
                    1'b0, NO_RES};
        plan[8]  = {mk_poll(32'd6200, 16'h0001, 8'hFF, 16'hFFFF, 8'hFF, 8'h22, 1'b1, 1'b0),
                    1'b1, mk_res(1'b1, TX_TIMEOUT, 1'b1, 1'b0, 1'b0, 1'b1)};
        plan[9]  = {mk_poll(32'd6100, 16'h0001, 8'hFF, 16'hFFFF, 8'hFF, 8'h33, 1'b0, 1'b0),
                    1'b0, NO_RES};
        plan[10] = {mk_poll(32'h8000_1838, 16'h0001, 8'hFF, 16'hFFFF, 8'hFF, 8'h44, 1'b0, 1'b0),
                    1'b0, NO_RES};
        plan[11] = {mk_poll(32'd6300, 16'h0001, 8'hFF, 16'hFFFF, 8'hFF, 8'h55, 1'b1, 1'b0),
                    1'b0, NO_RES};
        plan[12] = {mk_poll(32'd56300, 16'h0001, 8'hFF, 16'hFFFF, 8'hFF, 8'h66, 1'b0, 1'b0),
                    1'b0, NO_RES};
        plan[13] = {mk_poll(32'd56310, 16'h0001, 8'hFF, 16'hFFFF, 8'hFF, 8'h77, 1'b1, 1'b0),
                    1'b1, mk_res(1'b0, TX_ACKED, 1'b0, 1'b1, 1'b1, 1'b0)};
        plan[14] = {mk_poll(32'd1056310, 16'h0001, 8'hFF, 16'hFFFF, 8'hFF, 8'h88, 1'b0, 1'b0),
                    1'b1, mk_res(1'b1, TX_NONE, 1'b0, 1'b0, 1'b1, 1'b1)};
        plan[15] = {mk_poll(32'd1056320, 16'h0001, 8'hFF, 16'hFFFF, 8'hFF, 8'h99, 1'b1, 1'b0),
                    1'b0, NO_RES};
        plan[16] = {mk_poll(32'hFFFF_FFF0, 16'h0001, 8'hFF, 16'hFFFF, 8'hFF, 8'hAA, 1'b0, 1'b0),
                    1'b0, NO_RES};
        plan[17] = {mk_poll(32'h0000_0010, 16'h0001, 8'hFF, 16'hFFFF, 8'hFF, 8'hBB, 1'b1, 1'b0),
                    1'b0, NO_RES};
        plan[18] = {mk_poll(32'h0000_0020, 16'h0001, 8'hFF, 16'h0000, 8'h00, 8'hCC, 1'b0, 1'b0),
                    1'b0, NO_RES};
        plan[19] = {mk_poll(32'd884, 16'h0001, 8'hFF, 16'h0000, 8'h00, 8'hDD, 1'b0, 1'b0),
                    1'b0, NO_RES};
        plan[20] = {mk_poll(32'd900, 16'h0001, 8'hFF, 16'h0000, 8'h00, 8'hEE, 1'b1, 1'b0),
                    1'b0, NO_RES};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < ROWS; i++)
            send_poll(plan[i].poll, plan[i].typed, plan[i].want);

        cur   = plan[ROWS-1].poll;
        t_now = cur.now_us;
        for (int unsigned set = 0; set < 6; set++)
        begin
            case (set / 2)
                0:
                begin
                    send_idle_pct = 31;
                    recv_idle_pct = 88;
                end
                1:
                begin
                    send_idle_pct = 88;
                    recv_idle_pct = 31;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (set != 0)
            begin
                drain();
                configure(set);
            end
            for (int k = 0; k < PER_SET; k++)
            begin
                if (set == 4 && k == 40)
                    hold_req = 1'b1;
                next_poll(p);
                send_poll(p, 1'b0, NO_RES);
            end
        end
        drain();

        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### radio_report_send_scheduler.f
design/rrss_pkg.sv
design/radio_report_send_scheduler.sv
verif/tb.sv
